// ----- design/integer_field_formatter_assert.svh -----
// Assertion macros shared by the formatter RTL.
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef INTEGER_FIELD_FORMATTER_ASSERT_SVH
`define INTEGER_FIELD_FORMATTER_ASSERT_SVH

// Check a condition in the same cycle as its trigger
`define IFF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Check a condition in the cycle after its trigger
`define IFF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/iff_pkg.sv -----
package iff_pkg;

	// Conversion kinds
	localparam logic [2:0] CONV_SDEC = 3'd0;
	localparam logic [2:0] CONV_UDEC = 3'd1;
	localparam logic [2:0] CONV_OCT  = 3'd2;
	localparam logic [2:0] CONV_HEXL = 3'd3;
	localparam logic [2:0] CONV_HEXU = 3'd4;

	// ASCII codes
	localparam logic [6:0] CH_SPACE = 7'h20;
	localparam logic [6:0] CH_PLUS  = 7'h2B;
	localparam logic [6:0] CH_MINUS = 7'h2D;
	localparam logic [6:0] CH_ZERO  = 7'h30;
	localparam logic [6:0] CH_UA    = 7'h41;
	localparam logic [6:0] CH_LA    = 7'h61;

	typedef struct packed {
		logic [31:0] value;
		logic [2:0]  conversion;
		logic        left_align;
		logic        force_plus;
		logic        zero_fill;
		logic        blank_sign;
		logic [5:0]  field_width;
		logic [5:0]  min_precision;
	} fmt_in_t;

	typedef struct packed {
		logic [6:0] char_code;
		logic       last_char;
	} fmt_out_t;

	// Map one digit 0..15 to its ASCII character
	function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
		logic [6:0] r;
		if (d < 4'd10) begin
			r = CH_ZERO + {3'b000, d};
		end else if (upper) begin
			r = CH_UA + {3'b000, d} - 7'd10;
		end else begin
			r = CH_LA + {3'b000, d} - 7'd10;
		end
		return r;
	endfunction

endpackage

// ----- design/integer_field_formatter.sv -----
// Formats one integer as printf-style text (%d, %u, %o, %x, %X with width, precision, '-',
// '+', ' ' and '0' flags) and returns it one ASCII character per transaction, the final
// character flagged by last_char. An item is taken only while the block is idle. Decimal
// items first pass all VALUE_BITS value bits through a shift-and-add-3 BCD converter; every
// kind then scans the digit slots for the leading digit ((VALUE_BITS+2)/3 slots at most),
// passes one setup state, and emits one character per cycle while the result side does not
// stall. Codes 5 to 7 are accepted and produce no characters.
`include "integer_field_formatter_assert.svh"

module integer_field_formatter #(
	parameter int MAX_FIELD_WIDTH = 63,
	parameter int VALUE_BITS      = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             src_valid,
	output logic             src_stall,
	input  iff_pkg::fmt_in_t src_item,
	output logic             res_valid,
	input  logic             res_stall,
	output iff_pkg::fmt_out_t res_item
);
	import iff_pkg::*;

	localparam int NDIG = (VALUE_BITS + 2) / 3;
	localparam int IW   = $clog2(NDIG);
	localparam int BW   = $clog2(VALUE_BITS + 1);
	localparam int WW   = $clog2(MAX_FIELD_WIDTH + NDIG + 2);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DABBLE = 4'd1;
	localparam logic [3:0] S_SCAN   = 4'd2;
	localparam logic [3:0] S_SETUP  = 4'd3;
	localparam logic [3:0] S_LPAD   = 4'd4;
	localparam logic [3:0] S_SIGN   = 4'd5;
	localparam logic [3:0] S_ZPAD   = 4'd6;
	localparam logic [3:0] S_DIGIT  = 4'd7;
	localparam logic [3:0] S_RPAD   = 4'd8;

	logic [3:0]            state_q;
	logic [3:0]            dig_q [NDIG];
	logic [VALUE_BITS-1:0] vsh_q;
	logic [BW-1:0]         bit_cnt_q;
	logic [IW-1:0]         idx_q;
	logic [WW-1:0]         cnt_q;
	logic                  upper_q;
	logic                  left_q;
	logic                  zero_q;
	logic                  has_sym_q;
	logic [6:0]            sym_q;
	logic [5:0]            fw_q;
	logic [5:0]            prec_q;
	logic                  res_valid_q;
	fmt_out_t              res_item_q;

	// Operand view at VALUE_BITS
	logic [VALUE_BITS+31:0]  vcat;
	logic [VALUE_BITS-1:0]   vin;
	logic                    vneg;
	logic [VALUE_BITS-1:0]   vmag;
	logic [NDIG*4-1:0]       vpad;
	logic [3:0]              adj [NDIG];

	assign vcat = {{VALUE_BITS{1'b0}}, src_item.value};
	assign vin  = vcat[VALUE_BITS-1:0];
	assign vneg = (src_item.conversion == CONV_SDEC) && vin[VALUE_BITS-1];
	assign vmag = vneg ? (~vin + VALUE_BITS'(1)) : vin;
	assign vpad = (NDIG*4)'(vin);

	// Add three to every BCD digit of five or more before the shift
	always_comb begin
		for (int i = 0; i < NDIG; i++) begin
			adj[i] = (dig_q[i] >= 4'd5) ? dig_q[i] + 4'd3 : dig_q[i];
		end
	end

	// Field geometry from digit count, sign and requested width
	logic [WW-1:0] req_w;
	logic [WW-1:0] len2;
	logic [WW-1:0] width_c;
	logic [WW-1:0] pad_c;

	always_comb begin
		req_w = (fw_q > prec_q) ? WW'(fw_q) : WW'(prec_q);
		if (req_w > WW'(MAX_FIELD_WIDTH)) begin
			req_w = WW'(MAX_FIELD_WIDTH);
		end
		len2    = WW'(idx_q) + WW'(1) + WW'(has_sym_q);
		width_c = (req_w > len2) ? req_w : len2;
		pad_c   = width_c - len2;
	end

	// Character for the current emit state
	logic       emitting;
	logic       out_free;
	logic       go;
	logic [6:0] char_c;
	logic       last_c;

	assign emitting = (state_q == S_LPAD) || (state_q == S_SIGN) || (state_q == S_ZPAD) ||
		(state_q == S_DIGIT) || (state_q == S_RPAD);
	assign out_free = !res_valid_q || !res_stall;
	assign go       = emitting && out_free;

	always_comb begin
		char_c = CH_SPACE;
		last_c = 1'b0;
		unique case (state_q)
			S_LPAD:  char_c = CH_SPACE;
			S_SIGN:  char_c = sym_q;
			S_ZPAD:  char_c = CH_ZERO;
			S_DIGIT: begin
				char_c = digit_char(dig_q[idx_q], upper_q);
				last_c = (idx_q == '0) && !(left_q && (cnt_q != '0));
			end
			S_RPAD: begin
				char_c = CH_SPACE;
				last_c = (cnt_q == WW'(1));
			end
			default: begin
				char_c = CH_SPACE;
				last_c = 1'b0;
			end
		endcase
	end

	// Sequencer: take item, convert, scan, then walk the field segments
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (src_valid) begin
						case (src_item.conversion) inside
							CONV_SDEC, CONV_UDEC: state_q <= S_DABBLE;
							CONV_OCT, CONV_HEXL, CONV_HEXU: state_q <= S_SCAN;
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_DABBLE: begin
					if (bit_cnt_q == BW'(1)) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if ((dig_q[idx_q] != 4'd0) || (idx_q == '0)) begin
						state_q <= S_SETUP;
					end
				end
				S_SETUP: begin
					if (!left_q && !zero_q && (pad_c != '0)) begin
						state_q <= S_LPAD;
					end else if (has_sym_q) begin
						state_q <= S_SIGN;
					end else if (!left_q && zero_q && (pad_c != '0)) begin
						state_q <= S_ZPAD;
					end else begin
						state_q <= S_DIGIT;
					end
				end
				S_LPAD: begin
					if (go && (cnt_q == WW'(1))) begin
						state_q <= has_sym_q ? S_SIGN : S_DIGIT;
					end
				end
				S_SIGN: begin
					if (go) begin
						state_q <= (!left_q && zero_q && (cnt_q != '0)) ? S_ZPAD : S_DIGIT;
					end
				end
				S_ZPAD: begin
					if (go && (cnt_q == WW'(1))) begin
						state_q <= S_DIGIT;
					end
				end
				S_DIGIT: begin
					if (go && (idx_q == '0)) begin
						state_q <= (left_q && (cnt_q != '0)) ? S_RPAD : S_IDLE;
					end
				end
				S_RPAD: begin
					if (go && (cnt_q == WW'(1))) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath: digit store, shifter, counters and item flags
	always_ff @(posedge clk) begin
		unique case (state_q) inside
			S_IDLE: begin
				if (src_valid) begin
					vsh_q     <= vmag;
					bit_cnt_q <= BW'(VALUE_BITS);
					idx_q     <= IW'(NDIG - 1);
					upper_q   <= (src_item.conversion == CONV_HEXU);
					left_q    <= src_item.left_align;
					zero_q    <= src_item.zero_fill;
					fw_q      <= src_item.field_width;
					prec_q    <= src_item.min_precision;
					has_sym_q <= vneg || src_item.force_plus || src_item.blank_sign;
					sym_q     <= vneg ? CH_MINUS : (src_item.force_plus ? CH_PLUS : CH_SPACE);
					for (int i = 0; i < NDIG; i++) begin
						case (src_item.conversion) inside
							CONV_OCT: dig_q[i] <= {1'b0, vpad[3*i +: 3]};
							CONV_HEXL, CONV_HEXU: dig_q[i] <= vpad[4*i +: 4];
							default: dig_q[i] <= 4'd0;
						endcase
					end
				end
			end
			S_DABBLE: begin
				dig_q[0] <= {adj[0][2:0], vsh_q[VALUE_BITS-1]};
				for (int i = 1; i < NDIG; i++) begin
					dig_q[i] <= {adj[i][2:0], adj[i-1][3]};
				end
				vsh_q     <= {vsh_q[VALUE_BITS-2:0], 1'b0};
				bit_cnt_q <= bit_cnt_q - BW'(1);
			end
			S_SCAN: begin
				if ((dig_q[idx_q] == 4'd0) && (idx_q != '0)) begin
					idx_q <= idx_q - IW'(1);
				end
			end
			S_SETUP: begin
				cnt_q <= pad_c;
			end
			S_LPAD, S_ZPAD, S_RPAD: begin
				if (go) begin
					cnt_q <= cnt_q - WW'(1);
				end
			end
			S_DIGIT: begin
				if (go && (idx_q != '0)) begin
					idx_q <= idx_q - IW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Output register: load on emit, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (go) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			res_item_q.char_code <= char_c;
			res_item_q.last_char <= last_c;
		end
	end

	assign src_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	`IFF_ASSERT_NEXT(a_dabble_done, (state_q == S_DABBLE) && (bit_cnt_q == BW'(1)), state_q == S_SCAN, "BCD conversion did not end after the last bit")
	`IFF_ASSERT_NOW(a_pad_nonzero, (state_q == S_LPAD) || (state_q == S_ZPAD) || (state_q == S_RPAD), cnt_q != '0, "padding state entered with no padding left")
	`IFF_ASSERT_NEXT(a_last_ends, go && last_c, state_q == S_IDLE, "final character emitted but sequencer still busy")
	`IFF_ASSERT_NOW(a_emit_flag, go && (state_q != S_DIGIT) && (state_q != S_RPAD), !last_c, "final marker set on a leading character")

endmodule
